/* hdl/pss_pkg.sv */
// ----------------------------------------------------------------------------
// pss_pkg
// Shared constants, codes and structs of the probabilistic step sequencer.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int NUM_STEPS  = 8;
  localparam int STEP_W     = $clog2(NUM_STEPS);
  localparam int SAMPLE_W   = 16;
  localparam int LEN_W      = 4;
  localparam int DIR_W      = 2;
  localparam int PROB_W     = 17;
  localparam int PULSE_W    = 16;
  localparam int DRAW_W     = 16;
  localparam int WIDX_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 24;

  // Schmitt thresholds, Q4.11 volts
  localparam logic signed [SAMPLE_W-1:0] THR_LOW  = 16'sd204;
  localparam logic signed [SAMPLE_W-1:0] THR_HIGH = 16'sd2048;

  localparam logic [LEN_W-1:0]   RST_SEQ_LENGTH = 4'd8;
  localparam logic [PROB_W-1:0]  RST_FIRE_PROB  = 17'd65536;
  localparam logic [PULSE_W-1:0] RST_PULSE_TICKS = 16'd48;

  typedef enum logic [DIR_W-1:0] {
    DIR_FWD  = 2'd0,
    DIR_BWD  = 2'd1,
    DIR_RND  = 2'd2,
    DIR_HOLD = 2'd3
  } pss_dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEQ_LENGTH  = 2'd0,
    REG_DIRECTION   = 2'd1,
    REG_FIRE_PROB   = 2'd2,
    REG_PULSE_TICKS = 2'd3
  } pss_reg_t;

  typedef enum logic {
    REQ_TICK  = 1'b0,
    REQ_WRITE = 1'b1
  } pss_req_t;

  typedef struct packed {
    logic [LEN_W-1:0]   seq_length;
    pss_dir_t           direction_mode;
    logic [PROB_W-1:0]  fire_probability;
    logic [PULSE_W-1:0] pulse_ticks;
  } pss_cfg_t;

  typedef struct packed {
    pss_req_t                    req_type;
    logic signed [SAMPLE_W-1:0]  clock_sample;
    logic signed [SAMPLE_W-1:0]  reset_sample;
    logic                        button_level;
    logic [DRAW_W-1:0]           gate_draw;
    logic [DRAW_W-1:0]           step_draw;
    logic [WIDX_W-1:0]           write_index;
    logic signed [SAMPLE_W-1:0]  write_value;
  } pss_item_t;

  typedef struct packed {
    logic [WIDX_W-1:0]          step_index;
    logic signed [SAMPLE_W-1:0] step_value;
    logic                       trigger_out;
    logic                       advanced;
  } pss_result_t;

endpackage

/* hdl/pss_cfg_regs.sv */
// ----------------------------------------------------------------------------
// pss_cfg_regs
// Configuration register file written through the cfg channel.
// ----------------------------------------------------------------------------
module pss_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pss_pkg::CFG_DATA_W-1:0]    cfg_data,
  output pss_pkg::pss_cfg_t                 cfg
);

  pss_pkg::pss_cfg_t cfg_r;
  pss_pkg::pss_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (pss_pkg::pss_reg_t'(cfg_index))
        pss_pkg::REG_SEQ_LENGTH:
          cfg_nxt.seq_length = cfg_data[pss_pkg::LEN_W-1:0];
        pss_pkg::REG_DIRECTION:
          cfg_nxt.direction_mode = pss_pkg::pss_dir_t'(cfg_data[pss_pkg::DIR_W-1:0]);
        pss_pkg::REG_FIRE_PROB:
          cfg_nxt.fire_probability = cfg_data[pss_pkg::PROB_W-1:0];
        pss_pkg::REG_PULSE_TICKS:
          cfg_nxt.pulse_ticks = cfg_data[pss_pkg::PULSE_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seq_length       <= pss_pkg::RST_SEQ_LENGTH;
      cfg_r.direction_mode   <= pss_pkg::DIR_FWD;
      cfg_r.fire_probability <= pss_pkg::RST_FIRE_PROB;
      cfg_r.pulse_ticks      <= pss_pkg::RST_PULSE_TICKS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* hdl/pss_seq_core.sv */
// ----------------------------------------------------------------------------
// pss_seq_core
// Sequencer state and the single-pass update for one item.
// ----------------------------------------------------------------------------
module pss_seq_core (
  input  logic                clk,
  input  logic                rst_n,
  input  pss_pkg::pss_cfg_t   cfg,
  input  logic                item_go,
  input  pss_pkg::pss_item_t  item,
  output pss_pkg::pss_result_t result
);

  localparam int STEP_W  = pss_pkg::STEP_W;
  localparam int LEN_W   = pss_pkg::LEN_W;
  localparam int PROD_W  = pss_pkg::DRAW_W + LEN_W;

  logic [STEP_W-1:0]            step_r, step_nxt;
  logic signed [pss_pkg::SAMPLE_W-1:0] store_r [pss_pkg::NUM_STEPS];
  logic                         clk_st_r, clk_st_nxt;
  logic                         rst_st_r, rst_st_nxt;
  logic                         btn_r, btn_nxt;
  logic [pss_pkg::PULSE_W-1:0]  pulse_r, pulse_nxt;

  logic [LEN_W-1:0]   len;
  logic [STEP_W-1:0]  len_m1;
  logic [STEP_W-1:0]  cs;
  logic [LEN_W-1:0]   cs_inc;
  logic [PROD_W-1:0]  prod;
  logic               clk_edge;
  logic               rst_edge;
  logic               btn_edge;
  logic               fire;
  logic               trig;
  logic               is_write;

  assign is_write = (item.req_type == pss_pkg::REQ_WRITE);

  always_comb begin
    if (cfg.seq_length == '0) begin
      len = LEN_W'(1);
    end else if (cfg.seq_length > LEN_W'(pss_pkg::NUM_STEPS)) begin
      len = LEN_W'(pss_pkg::NUM_STEPS);
    end else begin
      len = cfg.seq_length;
    end
  end

  assign len_m1 = STEP_W'(len - LEN_W'(1));
  assign cs     = ({1'b0, step_r} >= len) ? len_m1 : step_r;
  assign cs_inc = {1'b0, cs} + LEN_W'(1);
  assign prod   = {{LEN_W{1'b0}}, item.step_draw} * {{pss_pkg::DRAW_W{1'b0}}, len};
  assign trig   = (pulse_r != '0);

  always_comb begin
    clk_st_nxt = clk_st_r;
    clk_edge   = 1'b0;
    if (clk_st_r) begin
      if (item.clock_sample <= pss_pkg::THR_LOW) begin
        clk_st_nxt = 1'b0;
      end
    end else if (item.clock_sample >= pss_pkg::THR_HIGH) begin
      clk_st_nxt = 1'b1;
      clk_edge   = 1'b1;
    end
  end

  always_comb begin
    rst_st_nxt = rst_st_r;
    rst_edge   = 1'b0;
    if (rst_st_r) begin
      if (item.reset_sample <= pss_pkg::THR_LOW) begin
        rst_st_nxt = 1'b0;
      end
    end else if (item.reset_sample >= pss_pkg::THR_HIGH) begin
      rst_st_nxt = 1'b1;
      rst_edge   = 1'b1;
    end
  end

  assign btn_edge = item.button_level && !btn_r;
  assign fire     = (clk_edge || btn_edge) &&
                    ({1'b0, item.gate_draw} < cfg.fire_probability);

  logic               step_ch;
  logic               rst_st_keep;

  always_comb begin
    step_nxt    = cs;
    pulse_nxt   = trig ? pulse_r - pss_pkg::PULSE_W'(1) : pulse_r;
    step_ch     = 1'b0;
    rst_st_keep = clk_edge || btn_edge;
    if (fire) begin
      pulse_nxt = cfg.pulse_ticks;
      unique case (cfg.direction_mode)
        pss_pkg::DIR_FWD:  step_nxt = (cs_inc >= len) ? '0 : cs_inc[STEP_W-1:0];
        pss_pkg::DIR_BWD:  step_nxt = (cs == '0) ? len_m1 : cs - STEP_W'(1);
        pss_pkg::DIR_RND:  step_nxt = prod[pss_pkg::DRAW_W +: STEP_W];
        pss_pkg::DIR_HOLD: step_nxt = cs;
        default:           step_nxt = cs;
      endcase
    end else if (!rst_st_keep && rst_edge) begin
      unique case (cfg.direction_mode)
        pss_pkg::DIR_FWD:  step_nxt = '0;
        pss_pkg::DIR_RND:  step_nxt = '0;
        pss_pkg::DIR_BWD:  step_nxt = len_m1;
        pss_pkg::DIR_HOLD: step_nxt = cs;
        default:           step_nxt = cs;
      endcase
    end
    step_ch = 1'b1;
  end

  assign btn_nxt = item.button_level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= '0;
      clk_st_r <= 1'b0;
      rst_st_r <= 1'b0;
      btn_r    <= 1'b0;
      pulse_r  <= '0;
      for (int i = 0; i < pss_pkg::NUM_STEPS; i++) begin
        store_r[i] <= '0;
      end
    end else if (item_go) begin
      if (is_write) begin
        store_r[item.write_index[STEP_W-1:0]] <= item.write_value;
      end else begin
        if (step_ch) begin
          step_r <= step_nxt;
        end
        clk_st_r <= clk_st_nxt;
        if (!rst_st_keep) begin
          rst_st_r <= rst_st_nxt;
        end
        btn_r   <= btn_nxt;
        pulse_r <= pulse_nxt;
      end
    end
  end

  always_comb begin
    if (is_write) begin
      result.step_index  = pss_pkg::WIDX_W'(step_r);
      result.step_value  = (item.write_index[STEP_W-1:0] == step_r) ?
                           item.write_value : store_r[step_r];
      result.trigger_out = trig;
      result.advanced    = 1'b0;
    end else begin
      result.step_index  = pss_pkg::WIDX_W'(step_nxt);
      result.step_value  = store_r[step_nxt];
      result.trigger_out = trig;
      result.advanced    = fire;
    end
  end

endmodule

/* hdl/probabilistic_step_sequencer.sv */
// ----------------------------------------------------------------------------
// probabilistic_step_sequencer
// Eight-step control-voltage sequencer with a probability gate.
// ----------------------------------------------------------------------------
// Every item, a sample tick or a step-value write, returns exactly one result,
// passing first through the input register and then the output register.
// The step update is a single pass of logic between those two registers, so
// the block takes one item per clock cycle while the output side keeps up;
// when the output stalls, the input register holds one item and in_tready
// drops until the result drains. Configuration writes are always taken and
// should be issued only while no item is in flight.
// ----------------------------------------------------------------------------
module probabilistic_step_sequencer (
  input  logic                               clk,
  input  logic                               rst_n,
  // clock_sample[15:0], reset_sample[31:16], button_level[32],
  // gate_draw[48:33], step_draw[64:49], write_index[67:65],
  // write_value[83:68], zero fill [87:84]
  input  logic [pss_pkg::IN_DATA_W-1:0]      in_tdata,
  // req_type[0]
  input  logic                               in_tuser,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // step_index[2:0], step_value[18:3], trigger_out[19], advanced[20],
  // zero fill [23:21]
  output logic [pss_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pss_pkg::CFG_DATA_W-1:0]     cfg_data
);

  pss_pkg::pss_cfg_t    cfg;
  pss_pkg::pss_item_t   in_item;
  pss_pkg::pss_item_t   item_r;
  pss_pkg::pss_result_t result;
  pss_pkg::pss_result_t res_r;
  logic                 item_vld_r, item_vld_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic                 item_go;
  logic                 in_acc;

  assign in_item.req_type     = pss_pkg::pss_req_t'(in_tuser);
  assign in_item.clock_sample = in_tdata[15:0];
  assign in_item.reset_sample = in_tdata[31:16];
  assign in_item.button_level = in_tdata[32];
  assign in_item.gate_draw    = in_tdata[48:33];
  assign in_item.step_draw    = in_tdata[64:49];
  assign in_item.write_index  = in_tdata[67:65];
  assign in_item.write_value  = in_tdata[83:68];

  assign item_go   = item_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !item_vld_r || item_go;
  assign in_acc    = in_tvalid && in_tready;

  assign item_vld_nxt = in_acc ? 1'b1 : (item_go ? 1'b0 : item_vld_r);
  assign out_vld_nxt  = item_go ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);

  pss_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pss_seq_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .item_go (item_go),
    .item    (item_r),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_item;
    end
    if (item_go) begin
      res_r <= result;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, res_r.advanced, res_r.trigger_out,
                       res_r.step_value, res_r.step_index};

endmodule
